@@ sv/pidr_pkg.sv @@
// ----------------------------------------------------------------------------
// pidr_pkg
// Shared types, codes and the control program of the three-form pid regulator.
// ----------------------------------------------------------------------------
package pidr_pkg;

  localparam int PC_W      = 5;
  localparam int OP_W      = 4;
  localparam int SRC_W     = 5;
  localparam int COND_W    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int MUL_CHUNK = 16;

  // datapath operations
  localparam logic [OP_W-1:0] OP_NOP    = 4'd0;
  localparam logic [OP_W-1:0] OP_SUB    = 4'd1;
  localparam logic [OP_W-1:0] OP_ADD    = 4'd2;
  localparam logic [OP_W-1:0] OP_MUL    = 4'd3;
  localparam logic [OP_W-1:0] OP_SUBHI  = 4'd4;
  localparam logic [OP_W-1:0] OP_SUBLO  = 4'd5;
  localparam logic [OP_W-1:0] OP_ICLAMP = 4'd6;
  localparam logic [OP_W-1:0] OP_CLAMP  = 4'd7;
  localparam logic [OP_W-1:0] OP_CLEAR  = 4'd8;

  // operand sources and destinations
  localparam logic [SRC_W-1:0] R_ZERO  = 5'd0;
  localparam logic [SRC_W-1:0] R_REF   = 5'd1;
  localparam logic [SRC_W-1:0] R_FB    = 5'd2;
  localparam logic [SRC_W-1:0] R_ERR   = 5'd3;
  localparam logic [SRC_W-1:0] R_P     = 5'd4;
  localparam logic [SRC_W-1:0] R_D     = 5'd5;
  localparam logic [SRC_W-1:0] R_T     = 5'd6;
  localparam logic [SRC_W-1:0] R_U     = 5'd7;
  localparam logic [SRC_W-1:0] R_INTEG = 5'd8;
  localparam logic [SRC_W-1:0] R_PREV  = 5'd9;
  localparam logic [SRC_W-1:0] R_HI    = 5'd10;
  localparam logic [SRC_W-1:0] R_LO    = 5'd11;
  localparam logic [SRC_W-1:0] R_KP    = 5'd12;
  localparam logic [SRC_W-1:0] R_KI    = 5'd13;
  localparam logic [SRC_W-1:0] R_KD    = 5'd14;
  localparam logic [SRC_W-1:0] R_FFR   = 5'd15;
  localparam logic [SRC_W-1:0] R_FFB   = 5'd16;
  localparam logic [SRC_W-1:0] R_OMAX  = 5'd17;
  localparam logic [SRC_W-1:0] R_OMIN  = 5'd18;

  // jump conditions
  localparam logic [COND_W-1:0] C_NEXT   = 3'd0;
  localparam logic [COND_W-1:0] C_ALWAYS = 3'd1;
  localparam logic [COND_W-1:0] C_CLEAR  = 3'd2;
  localparam logic [COND_W-1:0] C_SERIAL = 3'd3;
  localparam logic [COND_W-1:0] C_PDFF   = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FORM = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KI   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OMIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OMAX = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FFR  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_FFB  = 3'd7;

  // program labels
  localparam logic [PC_W-1:0] L_PAR_D = 5'd3;
  localparam logic [PC_W-1:0] L_PDFF  = 5'd14;
  localparam logic [PC_W-1:0] L_SER   = 5'd18;
  localparam logic [PC_W-1:0] L_CLR   = 5'd23;
  localparam logic [PC_W-1:0] L_NONE  = 5'd0;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SRC_W-1:0]  src_a;
    logic [SRC_W-1:0]  src_b;
    logic [SRC_W-1:0]  dst;
    logic              bnd_out;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   target;
    logic              fin;
  } ctrl_t;

  typedef struct packed {
    ctrl_t cw;
    logic  commit;
    logic  mul_start;
  } dp_ctl_t;

  typedef struct packed {
    logic mul_done;
    logic clear;
    logic serial;
    logic pdff;
  } stat_t;

  function automatic ctrl_t mk(input logic [OP_W-1:0] op, input logic [SRC_W-1:0] a,
                               input logic [SRC_W-1:0] b, input logic [SRC_W-1:0] d,
                               input logic bnd, input logic [COND_W-1:0] c,
                               input logic [PC_W-1:0] t, input logic f);
    ctrl_t w;
    w.op      = op;
    w.src_a   = a;
    w.src_b   = b;
    w.dst     = d;
    w.bnd_out = bnd;
    w.cond    = c;
    w.target  = t;
    w.fin     = f;
    return w;
  endfunction

  // control store
  function automatic ctrl_t rom_word(input logic [PC_W-1:0] pc);
    ctrl_t w;
    unique case (pc)
      5'd0:  w = mk(OP_SUB,    R_REF,   R_FB,   R_ERR,   1'b0, C_CLEAR,  L_CLR,   1'b0);
      5'd1:  w = mk(OP_NOP,    R_ZERO,  R_ZERO, R_ZERO,  1'b0, C_PDFF,   L_PDFF,  1'b0);
      5'd2:  w = mk(OP_MUL,    R_KP,    R_ERR,  R_P,     1'b0, C_SERIAL, L_SER,   1'b0);
      // parallel body, also entered from pdff
      5'd3:  w = mk(OP_SUB,    R_ERR,   R_PREV, R_T,     1'b0, C_NEXT,   L_NONE,  1'b0);
      5'd4:  w = mk(OP_MUL,    R_KD,    R_T,    R_D,     1'b0, C_NEXT,   L_NONE,  1'b0);
      5'd5:  w = mk(OP_MUL,    R_KI,    R_ERR,  R_T,     1'b0, C_NEXT,   L_NONE,  1'b0);
      5'd6:  w = mk(OP_SUBHI,  R_OMAX,  R_P,    R_HI,    1'b0, C_NEXT,   L_NONE,  1'b0);
      5'd7:  w = mk(OP_SUBLO,  R_OMIN,  R_P,    R_LO,    1'b0, C_NEXT,   L_NONE,  1'b0);
      5'd8:  w = mk(OP_ADD,    R_INTEG, R_T,    R_T,     1'b0, C_NEXT,   L_NONE,  1'b0);
      5'd9:  w = mk(OP_ICLAMP, R_T,     R_ZERO, R_INTEG, 1'b0, C_NEXT,   L_NONE,  1'b0);
      5'd10: w = mk(OP_ADD,    R_P,     R_INTEG, R_T,    1'b0, C_NEXT,   L_NONE,  1'b0);
      5'd11: w = mk(OP_ADD,    R_T,     R_D,    R_T,     1'b0, C_NEXT,   L_NONE,  1'b0);
      5'd12: w = mk(OP_ADD,    R_ERR,   R_ZERO, R_PREV,  1'b0, C_NEXT,   L_NONE,  1'b0);
      5'd13: w = mk(OP_CLAMP,  R_T,     R_ZERO, R_ZERO,  1'b1, C_NEXT,   L_NONE,  1'b1);
      // pdff weighted error
      5'd14: w = mk(OP_MUL,    R_REF,   R_FFR,  R_T,     1'b0, C_NEXT,   L_NONE,  1'b0);
      5'd15: w = mk(OP_MUL,    R_FB,    R_FFB,  R_U,     1'b0, C_NEXT,   L_NONE,  1'b0);
      5'd16: w = mk(OP_SUB,    R_T,     R_U,    R_T,     1'b0, C_NEXT,   L_NONE,  1'b0);
      5'd17: w = mk(OP_MUL,    R_KP,    R_T,    R_P,     1'b0, C_ALWAYS, L_PAR_D, 1'b0);
      // serial pi
      5'd18: w = mk(OP_MUL,    R_KI,    R_P,    R_T,     1'b0, C_NEXT,   L_NONE,  1'b0);
      5'd19: w = mk(OP_ADD,    R_INTEG, R_T,    R_T,     1'b0, C_NEXT,   L_NONE,  1'b0);
      5'd20: w = mk(OP_ICLAMP, R_T,     R_ZERO, R_INTEG, 1'b1, C_NEXT,   L_NONE,  1'b0);
      5'd21: w = mk(OP_ADD,    R_P,     R_INTEG, R_T,    1'b0, C_NEXT,   L_NONE,  1'b0);
      5'd22: w = mk(OP_CLAMP,  R_T,     R_ZERO, R_ZERO,  1'b1, C_NEXT,   L_NONE,  1'b1);
      default: w = mk(OP_CLEAR, R_ZERO, R_ZERO, R_ZERO,  1'b0, C_NEXT,   L_NONE,  1'b1);
    endcase
    return w;
  endfunction

endpackage

@@ sv/pid_regulator_three_forms.sv @@
// ----------------------------------------------------------------------------
// pid_regulator_three_forms
// Three-form fixed-point pid regulator (parallel pid, serial pi, pdff).
// ----------------------------------------------------------------------------
// One transfer of reference and feedback gives one transfer of drive_value.
// Values are signed with FRAC_BITS fraction bits; every add, subtract and
// product saturates, products truncate toward zero. form_select picks the
// form (0 parallel pid with headroom anti-windup, 1 serial pi, 2 pdff,
// 3 acts as 0). clear_state zeroes integral and previous error and gives 0.
// Configuration writes are taken at any time but must only be issued while
// the block is idle. Items are worked one at a time by a microcoded
// sequencer over one shared multiplier. The next item is taken as soon as
// the last step retires, even while the previous result still waits in the
// output register.
// ----------------------------------------------------------------------------
module pid_regulator_three_forms #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_write,
  input  logic [pidr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_WIDTH-1:0]          cfg_data,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [DATA_WIDTH-1:0]          reference,
  input  logic [DATA_WIDTH-1:0]          feedback,
  input  logic                           integral_off,
  input  logic                           clear_state,
  // output channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [DATA_WIDTH-1:0]          drive_value
);
  import pidr_pkg::*;

  logic                  busy;
  logic                  accept;
  logic                  out_free;
  logic                  finish;
  logic [DATA_WIDTH-1:0] ref_q;
  logic [DATA_WIDTH-1:0] fb_q;
  logic                  ioff_q;
  logic                  clr_q;
  logic [DATA_WIDTH-1:0] result;
  dp_ctl_t               ctl;
  stat_t                 stat;

  // one item in flight; the input side waits only while the program runs
  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  // output register frees up in the same cycle its transfer happens
  assign out_free = !out_valid || !out_stall;
  assign finish   = ctl.commit && ctl.cw.fin;

  // capture the item for the length of its program
  always_ff @(posedge clk) begin
    if (accept) begin
      ref_q  <= reference;
      fb_q   <= feedback;
      ioff_q <= integral_off;
      clr_q  <= clear_state;
    end
  end

  pidr_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .out_free (out_free),
    .stat     (stat),
    .ctl      (ctl),
    .busy     (busy)
  );

  pidr_dp #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ref_q     (ref_q),
    .fb_q      (fb_q),
    .ioff_q    (ioff_q),
    .clr_q     (clr_q),
    .ctl       (ctl),
    .stat      (stat),
    .result    (result)
  );

  // output register, loaded by the final step of each program
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      drive_value <= result;
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst) accept |=> busy && !out_free
                                  || busy)
    else $error("accepted item did not start the sequencer");

endmodule

@@ sv/pidr_mul.sv @@
// ----------------------------------------------------------------------------
// pidr_mul
// Multi-cycle signed fixed-point multiplier with truncation and saturation.
// ----------------------------------------------------------------------------
module pidr_mul #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DATA_WIDTH-1:0] a,
  input  logic [DATA_WIDTH-1:0] b,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] result
);
  import pidr_pkg::*;

  localparam int W     = DATA_WIDTH;
  localparam int NCH   = (W + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int PAD_W = NCH * MUL_CHUNK;
  localparam int ACC_W = 2 * W;
  localparam int CNT_W = $clog2(NCH + 1);
  localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  logic                   run;
  logic [CNT_W-1:0]       cnt;
  logic                   neg;
  logic [W-1:0]           ua;
  logic [PAD_W-1:0]       ub;
  logic [ACC_W-1:0]       acc;
  logic [W-1:0]           a_mag;
  logic [W-1:0]           b_mag;
  logic [W+MUL_CHUNK-1:0] prod;
  logic [ACC_W-1:0]       acc_next;
  logic [ACC_W-1:0]       quo;
  logic                   ovf;

  assign a_mag    = a[W-1] ? (~a + W'(1)) : a;
  assign b_mag    = b[W-1] ? (~b + W'(1)) : b;
  // msb chunk first, so the running sum shifts by a constant
  assign prod     = ua * ub[PAD_W-1 -: MUL_CHUNK];
  assign acc_next = (acc << MUL_CHUNK) + ACC_W'(prod);
  assign quo      = acc >> FRAC_BITS;
  assign ovf      = |quo[ACC_W-1:W-1];

  always_comb begin
    if (ovf) begin
      result = neg ? VMIN : VMAX;
    end else if (neg) begin
      result = ~quo[W-1:0] + W'(1);
    end else begin
      result = quo[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(NCH);
      end else if (run) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= a[W-1] ^ b[W-1];
      ua  <= a_mag;
      ub  <= PAD_W'(b_mag);
      acc <= '0;
    end else if (run) begin
      acc <= acc_next;
      ub  <= ub << MUL_CHUNK;
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !run)
    else $error("multiplier done while still running");

endmodule

@@ sv/pidr_dp.sv @@
// ----------------------------------------------------------------------------
// pidr_dp
// Datapath: configuration registers, work registers, saturating alu, multiplier.
// ----------------------------------------------------------------------------
module pidr_dp #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [pidr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_WIDTH-1:0]          cfg_data,
  input  logic [DATA_WIDTH-1:0]          ref_q,
  input  logic [DATA_WIDTH-1:0]          fb_q,
  input  logic                           ioff_q,
  input  logic                           clr_q,
  input  pidr_pkg::dp_ctl_t              ctl,
  output pidr_pkg::stat_t                stat,
  output logic [DATA_WIDTH-1:0]          result
);
  import pidr_pkg::*;

  localparam int W = DATA_WIDTH;
  localparam logic [W-1:0] VMAX  = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] VMIN  = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] ONE_Q = (FRAC_BITS < W - 1) ?
                                   ({{(W-1){1'b0}}, 1'b1} << FRAC_BITS) : VMAX;

  logic [1:0]   form_select;
  logic [W-1:0] kp_gain, ki_ts_gain, kd_gain, out_min, out_max, ff_ref_gain, ff_fb_gain;
  logic [W-1:0] err, p, d, t, u, integ, prev, hi, lo;
  logic [W-1:0] a_val, b_val, r, s_sub, s_add, bnd_lo, bnd_hi, clamped;
  logic         mul_done;
  logic [W-1:0] mul_result;

  function automatic logic [W-1:0] sat_add(input logic [W-1:0] x, input logic [W-1:0] y);
    logic [W:0] s;
    s = {x[W-1], x} + {y[W-1], y};
    if (s[W] != s[W-1]) begin
      return s[W] ? VMIN : VMAX;
    end
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] sat_sub(input logic [W-1:0] x, input logic [W-1:0] y);
    logic [W:0] s;
    s = {x[W-1], x} - {y[W-1], y};
    if (s[W] != s[W-1]) begin
      return s[W] ? VMIN : VMAX;
    end
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] sel(input logic [SRC_W-1:0] code);
    logic [W-1:0] v;
    case (code)
      R_REF:   v = ref_q;
      R_FB:    v = fb_q;
      R_ERR:   v = err;
      R_P:     v = p;
      R_D:     v = d;
      R_T:     v = t;
      R_U:     v = u;
      R_INTEG: v = integ;
      R_PREV:  v = prev;
      R_HI:    v = hi;
      R_LO:    v = lo;
      R_KP:    v = kp_gain;
      R_KI:    v = ki_ts_gain;
      R_KD:    v = kd_gain;
      R_FFR:   v = ff_ref_gain;
      R_FFB:   v = ff_fb_gain;
      R_OMAX:  v = out_max;
      R_OMIN:  v = out_min;
      default: v = '0;
    endcase
    return v;
  endfunction

  assign a_val  = sel(ctl.cw.src_a);
  assign b_val  = sel(ctl.cw.src_b);
  assign s_sub  = sat_sub(a_val, b_val);
  assign s_add  = sat_add(a_val, b_val);
  assign bnd_lo = ctl.cw.bnd_out ? out_min : lo;
  assign bnd_hi = ctl.cw.bnd_out ? out_max : hi;

  // upper bound first, then lower bound wins
  always_comb begin
    clamped = a_val;
    if ($signed(clamped) > $signed(bnd_hi)) begin
      clamped = bnd_hi;
    end
    if ($signed(clamped) < $signed(bnd_lo)) begin
      clamped = bnd_lo;
    end
  end

  always_comb begin
    unique case (ctl.cw.op)
      OP_SUB:    r = s_sub;
      OP_ADD:    r = s_add;
      OP_MUL:    r = mul_result;
      OP_SUBHI:  r = s_sub[W-1] ? '0 : s_sub;
      OP_SUBLO:  r = (!s_sub[W-1] && (s_sub != '0)) ? '0 : s_sub;
      OP_ICLAMP: r = ioff_q ? '0 : clamped;
      OP_CLAMP:  r = clamped;
      default:   r = '0;
    endcase
  end

  assign result = r;

  pidr_mul #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (ctl.mul_start),
    .a      (a_val),
    .b      (b_val),
    .done   (mul_done),
    .result (mul_result)
  );

  assign stat.mul_done = mul_done;
  assign stat.clear    = clr_q;
  assign stat.serial   = (form_select == 2'd1);
  assign stat.pdff     = (form_select == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      form_select <= 2'd0;
      kp_gain     <= '0;
      ki_ts_gain  <= '0;
      kd_gain     <= '0;
      out_min     <= VMIN;
      out_max     <= VMAX;
      ff_ref_gain <= ONE_Q;
      ff_fb_gain  <= ONE_Q;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_FORM: form_select <= cfg_data[1:0];
        CFG_KP:   kp_gain     <= cfg_data;
        CFG_KI:   ki_ts_gain  <= cfg_data;
        CFG_KD:   kd_gain     <= cfg_data;
        CFG_OMIN: out_min     <= cfg_data;
        CFG_OMAX: out_max     <= cfg_data;
        CFG_FFR:  ff_ref_gain <= cfg_data;
        CFG_FFB:  ff_fb_gain  <= cfg_data;
        default: ;
      endcase
    end
  end

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      integ <= '0;
      prev  <= '0;
    end else if (ctl.commit) begin
      if (ctl.cw.op == OP_CLEAR) begin
        integ <= '0;
        prev  <= '0;
      end else if (ctl.cw.dst == R_INTEG) begin
        integ <= r;
      end else if (ctl.cw.dst == R_PREV) begin
        prev <= r;
      end
    end
  end

  // scratch registers
  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      case (ctl.cw.dst)
        R_ERR:   err <= r;
        R_P:     p   <= r;
        R_D:     d   <= r;
        R_T:     t   <= r;
        R_U:     u   <= r;
        R_HI:    hi  <= r;
        R_LO:    lo  <= r;
        default: ;
      endcase
    end
  end

endmodule

@@ sv/pidr_seq.sv @@
// ----------------------------------------------------------------------------
// pidr_seq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
module pidr_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              out_free,
  input  pidr_pkg::stat_t   stat,
  output pidr_pkg::dp_ctl_t ctl,
  output logic              busy
);
  import pidr_pkg::*;

  logic [PC_W-1:0] pc;
  logic            mul_run;
  ctrl_t           cw;
  logic            take;
  logic            commit;
  logic            mul_start;

  assign cw = rom_word(pc);

  always_comb begin
    unique case (cw.cond)
      C_ALWAYS: take = 1'b1;
      C_CLEAR:  take = stat.clear;
      C_SERIAL: take = stat.serial;
      C_PDFF:   take = stat.pdff;
      default:  take = 1'b0;
    endcase
  end

  // a multiply step waits for the unit, a final step waits for a free output slot
  assign mul_start = busy && (cw.op == OP_MUL) && !mul_run;
  assign commit    = busy && ((cw.op != OP_MUL) || stat.mul_done) && (!cw.fin || out_free);

  assign ctl.cw        = cw;
  assign ctl.commit    = commit;
  assign ctl.mul_start = mul_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      pc      <= '0;
      mul_run <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        pc   <= '0;
      end else if (commit) begin
        pc <= take ? cw.target : pc + PC_W'(1);
        if (cw.fin) begin
          busy <= 1'b0;
        end
      end
      if (mul_start) begin
        mul_run <= 1'b1;
      end else if (commit) begin
        mul_run <= 1'b0;
      end
    end
  end

  a_mul_latency: assert property (@(posedge clk) disable iff (rst) mul_start |=> !commit)
    else $error("multiply step retired one cycle after launch");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst) !busy |-> !commit && !mul_start)
    else $error("control step retired while idle");

  a_fin_idle: assert property (@(posedge clk) disable iff (rst) (commit && cw.fin) |=> !busy)
    else $error("sequencer still busy after final step");

endmodule
